// File: hw/rtl/qbsr_pkg.sv
// shared types and constants for the quad bridge converter serial reader
`default_nettype none
package qbsr_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int TICK_W      = 16;
  localparam int PULSE_W     = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYPASS_MASK  = 2'd0,
    CFG_TOTAL_PULSES = 2'd1,
    CFG_HALF_PERIOD  = 2'd2
  } cfg_index_t;

  localparam logic [PULSE_W-1:0] TOTAL_PULSES_RST = 5'd25;
  localparam logic [TICK_W-1:0]  HALF_PERIOD_RST  = 16'd50;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [CHANNELS-1:0] bypass_mask;
    logic [PULSE_W-1:0]  total_pulses;
    logic [TICK_W-1:0]   half_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic    serial_clock;
    logic    busy_res;
    logic    done_res;
    logic    not_ready;
    sample_t value_0;
    sample_t value_1;
    sample_t value_2;
    sample_t value_3;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/qbsr_if.sv
// valid/ready channel interfaces for tick items and result items
`default_nettype none
interface qbsr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          start_request;
  logic [qbsr_pkg::CHANNELS-1:0] data_lines;

  modport source (output valid, output start_request, output data_lines, input ready);
  modport sink   (input valid, input start_request, input data_lines, output ready);
endinterface

interface qbsr_out_if;
  logic              valid;
  logic              ready;
  logic              serial_clock;
  logic              busy_res;
  logic              done_res;
  logic              not_ready;
  qbsr_pkg::sample_t value_0;
  qbsr_pkg::sample_t value_1;
  qbsr_pkg::sample_t value_2;
  qbsr_pkg::sample_t value_3;

  modport source (
    output valid, output serial_clock, output busy_res, output done_res, output not_ready,
    output value_0, output value_1, output value_2, output value_3, input ready
  );
  modport sink (
    input valid, input serial_clock, input busy_res, input done_res, input not_ready,
    input value_0, input value_1, input value_2, input value_3, output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/qbsr_cfg.sv
// configuration registers written through the plain write port
`default_nettype none
module qbsr_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [qbsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [qbsr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output qbsr_pkg::cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bypass_mask       <= '0;
      cfg.total_pulses      <= qbsr_pkg::TOTAL_PULSES_RST;
      cfg.half_period_ticks <= qbsr_pkg::HALF_PERIOD_RST;
    end else if (cfg_wen) begin
      case (qbsr_pkg::cfg_index_t'(cfg_index))
        qbsr_pkg::CFG_BYPASS_MASK: begin
          cfg.bypass_mask <= cfg_data[qbsr_pkg::CHANNELS-1:0];
        end
        qbsr_pkg::CFG_TOTAL_PULSES: begin
          cfg.total_pulses <= cfg_data[qbsr_pkg::PULSE_W-1:0];
        end
        qbsr_pkg::CFG_HALF_PERIOD: begin
          cfg.half_period_ticks <= cfg_data[qbsr_pkg::TICK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/qbsr_engine.sv
// serial clock sequencer and per-channel shift registers, one step per tick
`default_nettype none
module qbsr_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic                          start_request,
  input  wire logic [qbsr_pkg::CHANNELS-1:0] data_lines,
  input  qbsr_pkg::cfg_t                     cfg,
  output qbsr_pkg::result_t                  res
);

  localparam logic [qbsr_pkg::PULSE_W:0] MIN_PULSES = (qbsr_pkg::PULSE_W + 1)'(qbsr_pkg::SAMPLE_BITS);

  qbsr_pkg::phase_t                  phase, phase_next;
  logic [qbsr_pkg::TICK_W-1:0]       tick_count, tick_count_next;
  logic [qbsr_pkg::PULSE_W-1:0]      pulse_count, pulse_count_next;
  qbsr_pkg::sample_t                 shift_regs [qbsr_pkg::CHANNELS];
  qbsr_pkg::sample_t                 shift_regs_next [qbsr_pkg::CHANNELS];
  qbsr_pkg::sample_t                 shifted [qbsr_pkg::CHANNELS];
  logic [qbsr_pkg::PULSE_W:0]        total_eff;
  logic [qbsr_pkg::PULSE_W:0]        pulse_inc;
  logic [qbsr_pkg::TICK_W-1:0]       tick_inc;
  logic                              half_done;
  logic                              all_ready;

  assign total_eff = ({1'b0, cfg.total_pulses} < MIN_PULSES) ? MIN_PULSES
                                                              : {1'b0, cfg.total_pulses};
  assign pulse_inc = {1'b0, pulse_count} + 1'b1;
  assign tick_inc  = tick_count + 1'b1;
  // zero half period acts as one tick since the count starts at one
  assign half_done = (tick_count >= cfg.half_period_ticks);
  assign all_ready = &(~data_lines | cfg.bypass_mask);

  always_comb begin
    for (int j = 0; j < qbsr_pkg::CHANNELS; j++) begin
      // only the first sample bits are captured, gain pulses shift nothing
      shifted[j] = ({1'b0, pulse_count} < MIN_PULSES)
                   ? {shift_regs[j][qbsr_pkg::SAMPLE_BITS-2:0], data_lines[j]}
                   : shift_regs[j];
    end
  end

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    pulse_count_next = pulse_count;
    for (int j = 0; j < qbsr_pkg::CHANNELS; j++) begin
      shift_regs_next[j] = shift_regs[j];
    end
    res = '0;
    case (phase)
      qbsr_pkg::PH_HIGH: begin
        res.busy_res = 1'b1;
        if (half_done) begin
          phase_next      = qbsr_pkg::PH_LOW;
          tick_count_next = 16'd1;
        end else begin
          tick_count_next  = tick_inc;
          res.serial_clock = 1'b1;
        end
      end
      qbsr_pkg::PH_LOW: begin
        if (half_done) begin
          for (int j = 0; j < qbsr_pkg::CHANNELS; j++) begin
            shift_regs_next[j] = shifted[j];
          end
          pulse_count_next = pulse_inc[qbsr_pkg::PULSE_W-1:0];
          if (pulse_inc >= total_eff) begin
            phase_next      = qbsr_pkg::PH_IDLE;
            tick_count_next = '0;
            res.done_res    = 1'b1;
            res.value_0     = shifted[0];
            res.value_1     = shifted[1];
            res.value_2     = shifted[2];
            res.value_3     = shifted[3];
          end else begin
            phase_next       = qbsr_pkg::PH_HIGH;
            tick_count_next  = 16'd1;
            res.serial_clock = 1'b1;
            res.busy_res     = 1'b1;
          end
        end else begin
          tick_count_next = tick_inc;
          res.busy_res    = 1'b1;
        end
      end
      default: begin
        phase_next = qbsr_pkg::PH_IDLE;
        if (start_request) begin
          if (!all_ready) begin
            res.not_ready = 1'b1;
          end else begin
            for (int j = 0; j < qbsr_pkg::CHANNELS; j++) begin
              shift_regs_next[j] = '0;
            end
            phase_next       = qbsr_pkg::PH_HIGH;
            tick_count_next  = 16'd1;
            pulse_count_next = '0;
            res.serial_clock = 1'b1;
            res.busy_res     = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= qbsr_pkg::PH_IDLE;
      tick_count  <= '0;
      pulse_count <= '0;
      for (int j = 0; j < qbsr_pkg::CHANNELS; j++) begin
        shift_regs[j] <= '0;
      end
    end else if (step) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      pulse_count <= pulse_count_next;
      for (int j = 0; j < qbsr_pkg::CHANNELS; j++) begin
        shift_regs[j] <= shift_regs_next[j];
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/qbsr_out_stage.sv
// result register between the sequencer and the output channel
`default_nettype none
module qbsr_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  qbsr_pkg::result_t  res,
  qbsr_out_if.source         out
);

  logic              valid;
  qbsr_pkg::result_t held;

  // a new result may enter when the register is empty or is draining this cycle
  assign in_ready = !valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held <= res;
    end
  end

  assign out.valid        = valid;
  assign out.serial_clock = held.serial_clock;
  assign out.busy_res     = held.busy_res;
  assign out.done_res     = held.done_res;
  assign out.not_ready    = held.not_ready;
  assign out.value_0      = held.value_0;
  assign out.value_1      = held.value_1;
  assign out.value_2      = held.value_2;
  assign out.value_3      = held.value_3;

endmodule
`default_nettype wire

// File: hw/rtl/quad_bridge_adc_serial_reader_core.sv
// Four-channel bridge converter serial reader, top level.
// Each transfer on the in channel is one timing tick: a read request and the
// sampled data line of each of the four converters. Each tick gives exactly
// one transfer on the out channel: the serial clock level to drive, busy,
// done, not-ready, and the four signed 24-bit readings (zero unless done).
// A request while idle starts a read when every line is low or bypassed,
// otherwise not_ready is flagged for that tick. Each clock pulse spans
// half_period_ticks high and then low; one bit per channel is shifted in at
// the end of each low half for the first 24 pulses, extra pulses set gain.
// A taken tick's result appears in the next cycle, in a single result register.
// Throughput is one tick per cycle; in.ready stays high while the result
// register is empty or being taken, so a stalled receiver stalls input ticks
// without losing or repeating any. The user must write the configuration port
// (cfg_wen, cfg_index, cfg_data) only while idle; the block does not enforce
// it. Synchronous reset puts the sequencer idle, clears the shift registers
// and loads the register defaults (no bypass, 25 pulses, 50 ticks per half).
`default_nettype none
module quad_bridge_adc_serial_reader_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic [qbsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qbsr_pkg::CFG_DATA_W-1:0] cfg_data,
  qbsr_in_if.sink                              in,
  qbsr_out_if.source                           out
);

  qbsr_pkg::cfg_t    cfg;
  qbsr_pkg::result_t res;
  logic              stage_ready;

  assign in.ready = stage_ready;

  qbsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qbsr_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .step          (in.valid && stage_ready),
    .start_request (in.start_request),
    .data_lines    (in.data_lines),
    .cfg           (cfg),
    .res           (res)
  );

  qbsr_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_ready (stage_ready),
    .res      (res),
    .out      (out)
  );

endmodule
`default_nettype wire
